// ===== src/spm_pkg.sv =====
`default_nettype none
package spm_pkg;

  // Fixed-point format of the averages and of the octave value.
  localparam int unsigned AVG_FRAC = 16;
  localparam int unsigned KNOB_BITS = 12;
  localparam int unsigned EXP_DEPTH = 64;
  localparam int unsigned EXP_IDX_BITS = $clog2(EXP_DEPTH);

  localparam logic [KNOB_BITS-1:0] KNOB_MAX = 12'd4095;
  // floor(2^42 / 4095): reciprocal used for the divide by the knob full scale.
  localparam logic [30:0] KNOB_RECIP = 31'd1074004032;
  localparam int unsigned RECIP_SHIFT = 42;
  localparam logic [18:0] OCT_QUARTER = 19'd16384;
  localparam logic [16:0] RATIO_NEAR = 17'd121242;
  localparam logic [16:0] RATIO_SPAN = 17'd85197;
  localparam logic [10:0] BASE_UNITS = 11'd1760;
  localparam logic [7:0] STATUS_INVALID = 8'd4;
  localparam logic [12:0] RANGE_RESET = 13'd250;
  localparam logic [4:0] DIV_STEPS_M1 = 5'd16;

  // Register indexes of the configuration port.
  localparam logic [2:0] CFG_KNOB_SMOOTHING = 3'd0;
  localparam logic [2:0] CFG_RANGE_SMOOTHING = 3'd1;
  localparam logic [2:0] CFG_NEAR_LIMIT = 3'd2;
  localparam logic [2:0] CFG_FAR_LIMIT = 3'd3;
  localparam logic [2:0] CFG_LOW_TONE = 3'd4;
  localparam logic [2:0] CFG_HIGH_TONE = 3'd5;

  typedef struct packed {
    logic [11:0] knob_sample;
    logic [12:0] range_mm;
    logic [7:0]  range_status;
  } spm_in_t;

  typedef struct packed {
    logic [15:0] tone_freq;
    logic [12:0] held_range_mm;
  } spm_out_t;

  typedef struct packed {
    logic [15:0] knob_smoothing;
    logic [15:0] range_smoothing;
    logic [12:0] near_limit_mm;
    logic [12:0] far_limit_mm;
    logic [15:0] low_tone_limit;
    logic [15:0] high_tone_limit;
  } spm_cfg_t;

  typedef struct packed {
    logic load;
    logic smooth;
    logic avg;
    logic prep;
    logic oct;
    logic interp;
    logic mant;
    logic div_step;
    logic ratio;
    logic prod;
    logic finish;
  } spm_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } spm_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_AVG,
    ST_PREP,
    ST_OCT,
    ST_INTERP,
    ST_MANT,
    ST_DIV,
    ST_RATIO,
    ST_PROD,
    ST_FINISH
  } spm_state_e;

  typedef logic [EXP_DEPTH:0][31:0] exp_tab_t;

  // Truncated Q1.30 power r^EXP_DEPTH, saturated just above 2^32.
  function automatic logic [63:0] pow_q30(logic [63:0] r);
    logic [63:0] acc;
    logic        sat;
    acc = 64'd1 << 30;
    sat = 1'b0;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      if (!sat) begin
        acc = (acc * r) >> 30;
        if (acc > (64'd1 << 32)) begin
          acc = (64'd1 << 32) + 64'd1;
          sat = 1'b1;
        end
      end
    end
    return acc;
  endfunction

  // Fraction table of 2^(i/EXP_DEPTH) in Q2.30, built at elaboration.
  function automatic exp_tab_t build_exp_table();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] acc;
    exp_tab_t    tab;
    lo = 64'd1 << 30;
    hi = 64'd1 << 31;
    for (int it = 0; it < 40; it++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow_q30(mid) <= (64'd1 << 31)) lo = mid;
        else hi = mid - 64'd1;
      end
    end
    acc = 64'd1 << 30;
    tab[0] = acc[31:0];
    for (int i = 1; i <= EXP_DEPTH; i++) begin
      acc = (acc * lo) >> 30;
      tab[i] = acc[31:0];
    end
    tab[EXP_DEPTH] = 32'h8000_0000;
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

// ===== src/spm_cfg_regs.sv =====
`default_nettype none
module spm_cfg_regs (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  output spm_pkg::spm_cfg_t       cfg_o
);

  spm_pkg::spm_cfg_t cfg_q;
  spm_pkg::spm_cfg_t cfg_d;

  // Decode one register write; unknown indexes leave everything alone.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        spm_pkg::CFG_KNOB_SMOOTHING:  cfg_d.knob_smoothing = cfg_data_i;
        spm_pkg::CFG_RANGE_SMOOTHING: cfg_d.range_smoothing = cfg_data_i;
        spm_pkg::CFG_NEAR_LIMIT:      cfg_d.near_limit_mm = cfg_data_i[12:0];
        spm_pkg::CFG_FAR_LIMIT:       cfg_d.far_limit_mm = cfg_data_i[12:0];
        spm_pkg::CFG_LOW_TONE:        cfg_d.low_tone_limit = cfg_data_i;
        spm_pkg::CFG_HIGH_TONE:       cfg_d.high_tone_limit = cfg_data_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.knob_smoothing <= 16'd7864;
      cfg_q.range_smoothing <= 16'd11796;
      cfg_q.near_limit_mm <= 13'd40;
      cfg_q.far_limit_mm <= 13'd600;
      cfg_q.low_tone_limit <= 16'd1440;
      cfg_q.high_tone_limit <= 16'd41600;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== src/spm_ctrl.sv =====
`default_nettype none
module spm_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  spm_pkg::spm_sts_t sts_i,
  output spm_pkg::spm_cmd_t cmd_o
);

  spm_pkg::spm_state_e state_q;
  spm_pkg::spm_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk the datapath through one item, one step per state; the divide state repeats until its last quotient bit.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      spm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = spm_pkg::ST_SMOOTH;
        end
      end
      spm_pkg::ST_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d = spm_pkg::ST_AVG;
      end
      spm_pkg::ST_AVG: begin
        cmd_o.avg = 1'b1;
        state_d = spm_pkg::ST_PREP;
      end
      spm_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = spm_pkg::ST_OCT;
      end
      spm_pkg::ST_OCT: begin
        cmd_o.oct = 1'b1;
        state_d = spm_pkg::ST_INTERP;
      end
      spm_pkg::ST_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d = spm_pkg::ST_MANT;
      end
      spm_pkg::ST_MANT: begin
        cmd_o.mant = 1'b1;
        state_d = spm_pkg::ST_DIV;
      end
      spm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = spm_pkg::ST_RATIO;
      end
      spm_pkg::ST_RATIO: begin
        cmd_o.ratio = 1'b1;
        state_d = spm_pkg::ST_PROD;
      end
      spm_pkg::ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = spm_pkg::ST_FINISH;
      end
      spm_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = spm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spm_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != spm_pkg::ST_IDLE);

endmodule
`default_nettype wire

// ===== src/spm_datapath.sv =====
`default_nettype none
module spm_datapath (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  spm_pkg::spm_cmd_t cmd_i,
  input  spm_pkg::spm_cfg_t cfg_i,
  input  spm_pkg::spm_in_t  in_data_i,
  input  wire logic         out_stall_i,
  output spm_pkg::spm_sts_t sts_o,
  output logic              out_valid_o,
  output spm_pkg::spm_out_t out_data_o
);

  localparam logic [27:0] KMAX_F = {spm_pkg::KNOB_MAX, 16'd0};

  // Item and state registers.
  logic [11:0] knob_q;
  logic [12:0] good_q;
  logic [27:0] kavg_q;
  logic [28:0] ravg_q;
  // Smoothing products.
  logic        kge_q, rge_q;
  logic [43:0] kprod_q;
  logic [44:0] rprod_q;
  // Octave path.
  logic [29:0] x_q;
  logic [17:0] qest_q;
  logic [1:0]  ip_q;
  logic [15:0] fr_q;
  logic [31:0] lo_q;
  logic [47:0] iprod_q;
  logic [45:0] base_q;
  // Distance path.
  logic [28:0] dn_q, den_q;
  logic        eq_q, rev_q, dnear_q;
  logic [45:0] rem_q, dsh_q;
  logic [16:0] quo_q;
  logic [4:0]  cnt_q;
  logic [16:0] ratio_q;
  logic [39:0] plo_q, phi_q;
  // Output register.
  spm_pkg::spm_out_t res_q;
  logic              res_valid_q;

  logic [27:0] ktgt, kdiff;
  logic [28:0] rtgt, rdiff;
  logic        kge, rge;
  logic [27:0] kc;
  logic [29:0] x;
  logic [60:0] qprod;
  logic [28:0] nearf, farf, dcl;
  logic [29:0] qm, rmd;
  logic [17:0] qc;
  logic [18:0] oct;
  logic [spm_pkg::EXP_IDX_BITS-1:0] idx;
  logic [spm_pkg::EXP_IDX_BITS:0]   idx_hi;
  logic [31:0] tlo, thi;
  logic [31:0] mant;
  logic [45:0] bprod;
  logic        dge;
  logic [16:0] tsub;
  logic [63:0] fsum;
  logic [17:0] fval;
  logic [15:0] fclamp;

  // Differences between targets and averages.
  always_comb begin
    ktgt = {knob_q, 16'd0};
    rtgt = {good_q, 16'd0};
    kge = (ktgt >= kavg_q);
    rge = (rtgt >= ravg_q);
    kdiff = kge ? (ktgt - kavg_q) : (kavg_q - ktgt);
    rdiff = rge ? (rtgt - ravg_q) : (ravg_q - rtgt);
  end

  // Knob scaling to octaves by reciprocal, and distance clamping.
  always_comb begin
    kc = (kavg_q > KMAX_F) ? KMAX_F : kavg_q;
    x = {2'd0, kc} + {1'b0, kc, 1'b0};
    qprod = 61'(x) * 61'(spm_pkg::KNOB_RECIP);
    nearf = {cfg_i.near_limit_mm, 16'd0};
    farf = {cfg_i.far_limit_mm, 16'd0};
    if (ravg_q < nearf) dcl = nearf;
    else if (ravg_q > farf) dcl = farf;
    else dcl = ravg_q;
  end

  // Quotient correction, table lookup, mantissa, base product and divider compare.
  always_comb begin
    qm = {qest_q, 12'd0} - 30'(qest_q);
    rmd = x_q - qm;
    qc = (rmd >= 30'(spm_pkg::KNOB_MAX)) ? (qest_q + 18'd1) : qest_q;
    oct = 19'(qc) + spm_pkg::OCT_QUARTER;
    idx = fr_q[15 -: spm_pkg::EXP_IDX_BITS];
    idx_hi = {1'b0, idx} + 1'b1;
    tlo = spm_pkg::EXP_TABLE[idx];
    thi = spm_pkg::EXP_TABLE[idx_hi];
    mant = lo_q + iprod_q[47:16];
    bprod = 46'(mant) * 46'(spm_pkg::BASE_UNITS);
    dge = (rem_q >= dsh_q);
  end

  // Ratio selection and final rounding and clamping.
  always_comb begin
    if (eq_q) tsub = '0;
    else if (rev_q) tsub = dnear_q ? 17'd0 : spm_pkg::RATIO_SPAN;
    else tsub = quo_q;
    fsum = {1'b0, phi_q, 23'd0} + 64'(plo_q) + (64'd1 << 45);
    fval = fsum[63:46];
    if (fval < {2'd0, cfg_i.low_tone_limit}) fclamp = cfg_i.low_tone_limit;
    else if (fval > {2'd0, cfg_i.high_tone_limit}) fclamp = cfg_i.high_tone_limit;
    else fclamp = fval[15:0];
  end

  // State that carries across items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q <= spm_pkg::RANGE_RESET;
      kavg_q <= '0;
      ravg_q <= {spm_pkg::RANGE_RESET, 16'd0};
      res_valid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.load && (in_data_i.range_status != spm_pkg::STATUS_INVALID)) begin
        good_q <= in_data_i.range_mm;
      end
      if (cmd_i.avg) begin
        kavg_q <= kge_q ? (kavg_q + kprod_q[43:16]) : (kavg_q - kprod_q[43:16]);
        ravg_q <= rge_q ? (ravg_q + rprod_q[44:16]) : (ravg_q - rprod_q[44:16]);
      end
      if (cmd_i.oct) cnt_q <= spm_pkg::DIV_STEPS_M1;
      else if (cmd_i.div_step) cnt_q <= cnt_q - 5'd1;
      if (cmd_i.finish) res_valid_q <= 1'b1;
      else if (!out_stall_i) res_valid_q <= 1'b0;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) knob_q <= in_data_i.knob_sample;
    if (cmd_i.smooth) begin
      kge_q <= kge;
      rge_q <= rge;
      kprod_q <= 44'(kdiff) * 44'(cfg_i.knob_smoothing);
      rprod_q <= 45'(rdiff) * 45'(cfg_i.range_smoothing);
    end
    if (cmd_i.prep) begin
      x_q <= x;
      qest_q <= qprod[59:spm_pkg::RECIP_SHIFT];
      dn_q <= dcl - nearf;
      den_q <= farf - nearf;
      eq_q <= (cfg_i.near_limit_mm == cfg_i.far_limit_mm);
      rev_q <= (cfg_i.near_limit_mm > cfg_i.far_limit_mm);
      dnear_q <= (dcl == nearf);
    end
    if (cmd_i.oct) begin
      ip_q <= oct[17:16];
      fr_q <= oct[15:0];
      rem_q <= 46'(dn_q) * 46'(spm_pkg::RATIO_SPAN);
      dsh_q <= {1'b0, den_q, 16'd0};
      quo_q <= '0;
    end
    if (cmd_i.interp) begin
      lo_q <= tlo;
      iprod_q <= 48'(thi - tlo) * 48'({fr_q[15-spm_pkg::EXP_IDX_BITS:0],
                                        6'd0});
    end
    if (cmd_i.mant) base_q <= bprod << ip_q;
    // Restoring divider, one quotient bit per step.
    if (cmd_i.div_step) begin
      if (dge) rem_q <= rem_q - dsh_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[15:0], dge};
    end
    if (cmd_i.ratio) ratio_q <= spm_pkg::RATIO_NEAR - tsub;
    if (cmd_i.prod) begin
      plo_q <= 40'(base_q[22:0]) * 40'(ratio_q);
      phi_q <= 40'(base_q[45:23]) * 40'(ratio_q);
    end
    if (cmd_i.finish) begin
      res_q.tone_freq <= fclamp;
      res_q.held_range_mm <= good_q;
    end
  end

  assign sts_o.div_last = (cnt_q == '0);
  assign sts_o.out_free = !res_valid_q || !out_stall_i;
  assign out_valid_o = res_valid_q;
  assign out_data_o = res_q;

endmodule
`default_nettype wire

// ===== src/sensor_pitch_mapper_core.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  in_data_i (knob, range, status)
// output    out        out_valid_o/out_stall_i out_data_o (tone, held range)
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Most of the work from acceptance to the result is the 17-step restoring
// divider of the distance ratio. The block works on one item at a time and
// stalls input meanwhile. Reset loads the register defaults and the averages
// with no clearing pass. A result waits in the output register while the next
// item is accepted.
`default_nettype none
module sensor_pitch_mapper_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  spm_pkg::spm_in_t       in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output spm_pkg::spm_out_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i
);

  spm_pkg::spm_cfg_t cfg;
  spm_pkg::spm_cmd_t cmd;
  spm_pkg::spm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  spm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== src/spm_checker.sv =====
`default_nettype none
module spm_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input spm_pkg::spm_out_t      out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // An accepted item keeps the block busy, so the input stays stalled.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input taken again too soon");

  // A new result only appears at the end of work on an item.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

bind sensor_pitch_mapper_core spm_checker u_spm_checker (.*);
`default_nettype wire
